// ===== rtl/serial_line_editor_core_assert.svh =====
// ----------------------------------------------------------------------------
// serial_line_editor_core_assert.svh
// Assertion macros shared by the line editor RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_EDITOR_CORE_ASSERT_SVH
`define SERIAL_LINE_EDITOR_CORE_ASSERT_SVH

`ifndef SYNTH

// Check a condition at every clock edge out of reset.
`define SLE_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check a consequence in the same cycle.
`define SLE_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the next cycle.
`define SLE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SLE_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define SLE_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define SLE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Types, character codes and controller/datapath interface for the line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  localparam int BUF_SIZE_DFLT = 64;
  localparam int DATA_W        = 8;
  localparam int COUNT_W       = 7;
  localparam int LIMIT_W       = 7;
  localparam int OP_W          = 2;
  localparam int KIND_W        = 2;
  localparam int TDATA_W       = 16;

  localparam logic [DATA_W-1:0] CH_CR    = 8'd13;
  localparam logic [DATA_W-1:0] CH_LF    = 8'd10;
  localparam logic [DATA_W-1:0] CH_BS    = 8'd8;
  localparam logic [DATA_W-1:0] CH_DEL   = 8'd127;
  localparam logic [DATA_W-1:0] CH_SPACE = 8'd32;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO      = 2'd0,
    KIND_LINE      = 2'd1,
    KIND_EMPTY     = 2'd2,
    KIND_NOT_READY = 2'd3
  } kind_t;

  // What the output register is loaded with.
  typedef enum logic [2:0] {
    EM_RX,
    EM_LF,
    EM_BS,
    EM_SPACE,
    EM_BS_LAST,
    EM_LINE,
    EM_EMPTY,
    EM_NOT_READY
  } emit_t;

  typedef struct packed {
    logic  take;
    logic  store_rx;
    logic  store_nl;
    logic  drop;
    logic  empty;
    logic  read_start;
    logic  line_adv;
    logic  emit;
    emit_t emit_sel;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic rx_nl;
    logic rx_bs;
    logic fill_zero;
    logic has_room;
    logic line_ready;
    logic n_zero;
    logic line_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/sle_ctrl.sv =====
// ----------------------------------------------------------------------------
// sle_ctrl
// Request sequencer: decodes each request and steps the datapath through
// its result sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_ctrl import sle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ECHO_RX,
    S_ECHO_LF,
    S_BS_FIRST,
    S_BS_SPACE,
    S_BS_LAST,
    S_NOT_READY,
    S_EMPTY,
    S_LINE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd           = '0;
    cmd.emit_sel  = EM_RX;
    state_next    = state;
    s_axis_tready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.take   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          OP_BYTE: begin
            if (sts.rx_nl) begin
              cmd.store_nl = 1'b1;
              state_next   = S_ECHO_LF;
            end else if (sts.rx_bs) begin
              if (sts.fill_zero) begin
                state_next = S_IDLE;
              end else begin
                cmd.drop   = 1'b1;
                state_next = S_BS_FIRST;
              end
            end else if (sts.has_room) begin
              cmd.store_rx = 1'b1;
              state_next   = S_ECHO_RX;
            end else begin
              // no room: drop silently
              state_next = S_IDLE;
            end
          end
          OP_READ: begin
            if (!sts.line_ready) begin
              state_next = S_NOT_READY;
            end else begin
              // latch the count and empty the store; memory keeps the bytes
              cmd.read_start = 1'b1;
              cmd.empty      = 1'b1;
              state_next     = sts.n_zero ? S_EMPTY : S_LINE;
            end
          end
          OP_CLEAR: begin
            cmd.empty  = 1'b1;
            state_next = S_IDLE;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_ECHO_RX: begin
        cmd.emit_sel = EM_RX;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ECHO_LF: begin
        cmd.emit_sel = EM_LF;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_BS_FIRST: begin
        cmd.emit_sel = EM_BS;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_BS_SPACE;
        end
      end
      S_BS_SPACE: begin
        cmd.emit_sel = EM_SPACE;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_BS_LAST;
        end
      end
      S_BS_LAST: begin
        cmd.emit_sel = EM_BS_LAST;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_NOT_READY: begin
        cmd.emit_sel = EM_NOT_READY;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMPTY: begin
        cmd.emit_sel = EM_EMPTY;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LINE: begin
        cmd.emit_sel = EM_LINE;
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.line_adv = 1'b1;
          if (sts.line_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sle_dp.sv =====
// ----------------------------------------------------------------------------
// sle_dp
// Line store, fill index, ready mark, read walker and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_line_editor_core_assert.svh"

module sle_dp import sle_pkg::*; #(
  parameter int BUF_SIZE = BUF_SIZE_DFLT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [OP_W-1:0]    opcode,
  input  logic [DATA_W-1:0]  rx_byte,
  input  logic [LIMIT_W-1:0] read_limit,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               out_ready,
  output logic               out_valid,
  output kind_t              out_kind,
  output logic [DATA_W-1:0]  out_byte,
  output logic [COUNT_W-1:0] out_count,
  output logic               out_last
);

  localparam int FILL_W = $clog2(BUF_SIZE + 1);
  localparam int ADDR_W = $clog2(BUF_SIZE);

  op_t                op_q;
  logic [DATA_W-1:0]  rx_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [FILL_W-1:0]  fill;
  logic               line_ready;
  logic [COUNT_W-1:0] n;
  logic [ADDR_W-1:0]  idx;
  logic [DATA_W-1:0]  mem [BUF_SIZE];
  logic [DATA_W-1:0]  rd_data;

  logic [LIMIT_W-1:0] lim_m1;
  logic [COUNT_W-1:0] fill_c;
  logic [COUNT_W-1:0] n_calc;
  logic [COUNT_W-1:0] idx_inc;
  logic               line_last;
  logic [ADDR_W-1:0]  rd_addr;
  logic               nl_room;
  logic               out_free;

  kind_t              kind_next;
  logic [DATA_W-1:0]  byte_next;
  logic [COUNT_W-1:0] count_next;
  logic               last_next;

  always_comb begin
    lim_m1    = limit_q - LIMIT_W'(1);
    fill_c    = COUNT_W'(fill);
    // deliver at most limit-1 bytes, none for a zero limit
    if (limit_q == '0) begin
      n_calc = '0;
    end else if (fill_c < lim_m1) begin
      n_calc = fill_c;
    end else begin
      n_calc = lim_m1;
    end
    idx_inc   = COUNT_W'(idx) + COUNT_W'(1);
    line_last = (idx_inc == n);
    nl_room   = (fill < FILL_W'(BUF_SIZE));
    out_free  = !out_valid || out_ready;
    // hold the address while stalled, step ahead when a byte goes out
    if (cmd.read_start) begin
      rd_addr = '0;
    end else if (cmd.line_adv && !line_last) begin
      rd_addr = idx + ADDR_W'(1);
    end else begin
      rd_addr = idx;
    end
  end

  always_comb begin
    sts.op         = op_q;
    sts.rx_nl      = (rx_q == CH_CR) || (rx_q == CH_LF);
    sts.rx_bs      = (rx_q == CH_BS) || (rx_q == CH_DEL);
    sts.fill_zero  = (fill == '0);
    sts.has_room   = (fill < FILL_W'(BUF_SIZE - 1));
    sts.line_ready = line_ready;
    sts.n_zero     = (n_calc == '0);
    sts.line_last  = line_last;
    sts.out_free   = out_free;
  end

  always_comb begin
    kind_next  = KIND_ECHO;
    byte_next  = '0;
    count_next = '0;
    last_next  = 1'b0;
    case (cmd.emit_sel)
      EM_RX: begin
        byte_next = rx_q;
        last_next = 1'b1;
      end
      EM_LF: begin
        byte_next = CH_LF;
        last_next = 1'b1;
      end
      EM_BS: begin
        byte_next = CH_BS;
      end
      EM_SPACE: begin
        byte_next = CH_SPACE;
      end
      EM_BS_LAST: begin
        byte_next = CH_BS;
        last_next = 1'b1;
      end
      EM_LINE: begin
        kind_next  = KIND_LINE;
        byte_next  = rd_data;
        count_next = n;
        last_next  = line_last;
      end
      EM_EMPTY: begin
        kind_next = KIND_EMPTY;
        last_next = 1'b1;
      end
      EM_NOT_READY: begin
        kind_next = KIND_NOT_READY;
        last_next = 1'b1;
      end
      default: begin
        kind_next = KIND_ECHO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      line_ready <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.empty) begin
        fill       <= '0;
        line_ready <= 1'b0;
      end else if (cmd.store_rx || (cmd.store_nl && nl_room)) begin
        fill <= fill + FILL_W'(1);
      end else if (cmd.drop) begin
        fill <= fill - FILL_W'(1);
      end
      if (cmd.store_nl) begin
        line_ready <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q    <= op_t'(opcode);
      rx_q    <= rx_byte;
      limit_q <= read_limit;
    end
    if (cmd.read_start) begin
      n   <= n_calc;
      idx <= '0;
    end else if (cmd.line_adv) begin
      idx <= idx + ADDR_W'(1);
    end
    if (cmd.emit) begin
      out_kind  <= kind_next;
      out_byte  <= byte_next;
      out_count <= count_next;
      out_last  <= last_next;
    end
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store_rx) begin
      mem[fill[ADDR_W-1:0]] <= rx_q;
    end else if (cmd.store_nl && nl_room) begin
      mem[fill[ADDR_W-1:0]] <= CH_LF;
    end
    rd_data <= mem[rd_addr];
  end

  `SLE_ASSERT_ALWAYS(a_fill_max, clk, rst, fill <= FILL_W'(BUF_SIZE), "fill beyond store size")
  `SLE_ASSERT_IMPLY(a_emit_free, clk, rst, cmd.emit, out_free, "result loaded over a pending one")
  `SLE_ASSERT_NEXT(a_read_empties, clk, rst, cmd.read_start, (fill == '0) && !line_ready, "read did not empty the store")
  `SLE_ASSERT_IMPLY(a_line_range, clk, rst, cmd.emit && (cmd.emit_sel == EM_LINE), (n != '0) && (idx_inc <= n), "line byte outside the latched count")

endmodule

`default_nettype wire

// ===== rtl/serial_line_editor_core.sv =====
// ----------------------------------------------------------------------------
// serial_line_editor_core
// Terminal line editor with echo: builds one line from received bytes and
// hands it out on a read request.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A received byte yields at most one echo
// result, or three for a backspace; a clear yields none. A read delivers up to
// BUF_SIZE line bytes, paced by the single read port of the line store and by
// output backpressure. The output register lets the next request be accepted
// while the last result is still waiting to be taken. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_line_editor_core import sle_pkg::*; #(
  parameter int BUF_SIZE = BUF_SIZE_DFLT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // [7:0] rx_byte, [14:8] read_limit
  input  logic [OP_W-1:0]    s_axis_tuser,   // [1:0] opcode
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // [7:0] out_byte, [14:8] out_count
  output logic [KIND_W-1:0]  m_axis_tuser,   // [1:0] out_kind
  output logic               m_axis_tlast
);

  cmd_t               cmd;
  sts_t               sts;
  kind_t              out_kind;
  logic [DATA_W-1:0]  out_byte;
  logic [COUNT_W-1:0] out_count;

  sle_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  sle_dp #(
    .BUF_SIZE (BUF_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .opcode     (s_axis_tuser),
    .rx_byte    (s_axis_tdata[DATA_W-1:0]),
    .read_limit (s_axis_tdata[DATA_W+LIMIT_W-1:DATA_W]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .out_count  (out_count),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {{(TDATA_W-DATA_W-COUNT_W){1'b0}}, out_count, out_byte};
  assign m_axis_tuser = out_kind;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the line editor core: a shadow copy of the line
// store predicts every echo and read result, and each result taken from the
// master side is compared with the oldest prediction. The sender idles in
// random bursts, the receiver throttles on its own pattern, and one long
// receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import sle_pkg::*;

  localparam int LINE_DEPTH  = BUF_SIZE_DFLT;
  localparam int REQUEST_MIN = 230;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    kind_t        kind;
    logic [7:0]   chr;
    logic [6:0]   count;
    logic         is_last;
  } line_result_t;

  typedef enum {RX_STEADY, RX_COIN, RX_EVERY_FOURTH, RX_RARE_STALL} rx_pace_t;

  // Shadow of the editor state plus the results it still owes.
  class line_echo_board;
    logic [7:0]   line_copy [LINE_DEPTH];
    int           fill;
    bit           ready;
    line_result_t pending_results [$];
    int           mismatches;

    function new();
      fill = 0;
      ready = 0;
      mismatches = 0;
    endfunction

    function void owe(kind_t kind, logic [7:0] chr, logic [6:0] count, logic is_last);
      line_result_t r;
      r.kind = kind;
      r.chr = chr;
      r.count = count;
      r.is_last = is_last;
      pending_results.push_back(r);
    endfunction

    function void note_request(op_t op, logic [7:0] chr, logic [6:0] lim);
      int n;
      case (op)
        OP_BYTE: begin
          if (chr == CH_CR || chr == CH_LF) begin
            // a newline into a full store is echoed but not kept
            if (fill < LINE_DEPTH) begin
              line_copy[fill] = CH_LF;
              fill++;
            end
            ready = 1;
            owe(KIND_ECHO, CH_LF, 7'd0, 1'b1);
          end else if (chr == CH_BS || chr == CH_DEL) begin
            if (fill != 0) begin
              fill--;
              owe(KIND_ECHO, CH_BS, 7'd0, 1'b0);
              owe(KIND_ECHO, CH_SPACE, 7'd0, 1'b0);
              owe(KIND_ECHO, CH_BS, 7'd0, 1'b1);
            end
          end else if (fill < LINE_DEPTH - 1) begin
            line_copy[fill] = chr;
            fill++;
            owe(KIND_ECHO, chr, 7'd0, 1'b1);
          end
        end
        OP_READ: begin
          if (!ready) begin
            owe(KIND_NOT_READY, 8'd0, 7'd0, 1'b1);
          end else begin
            n = fill;
            if (lim == 0) n = 0;
            else if (n > int'(lim) - 1) n = int'(lim) - 1;
            if (n == 0) owe(KIND_EMPTY, 8'd0, 7'd0, 1'b1);
            for (int i = 0; i < n; i++)
              owe(KIND_LINE, line_copy[i], 7'(n), (i == n - 1));
            fill = 0;
            ready = 0;
          end
        end
        OP_CLEAR: begin
          fill = 0;
          ready = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_output(logic [1:0] kind, logic [7:0] chr, logic [6:0] count,
                               logic is_last);
      line_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d byte=%h count=%0d last=%b",
                 $time, kind, chr, count, is_last);
        mismatches++;
        return;
      end
      e = pending_results.pop_front();
      if (kind !== e.kind) begin
        $display("%0t: out_kind expected %0d actual %0d", $time, e.kind, kind);
        mismatches++;
      end
      if (chr !== e.chr) begin
        $display("%0t: out_byte expected %h actual %h", $time, e.chr, chr);
        mismatches++;
      end
      if (count !== e.count) begin
        $display("%0t: out_count expected %0d actual %0d", $time, e.count, count);
        mismatches++;
      end
      if (is_last !== e.is_last) begin
        $display("%0t: last expected %b actual %b", $time, e.is_last, is_last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;   // [7:0] rx_byte, [14:8] read_limit
  logic [OP_W-1:0]    s_axis_tuser = '0;   // [1:0] opcode
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;        // [7:0] out_byte, [14:8] out_count
  logic [KIND_W-1:0]  m_axis_tuser;        // [1:0] out_kind
  logic               m_axis_tlast;

  line_echo_board board = new();
  int requests_sent  = 0;
  int requests_taken = 0;
  int burst_left     = 0;

  serial_line_editor_core #(.BUF_SIZE(LINE_DEPTH)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      board.note_request(op_t'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[14:8]);
      requests_taken++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_output(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[14:8],
                         m_axis_tlast);
  end

  // Offer one request and hold it until taken; idle between bursts.
  task automatic send_request(op_t op, logic [7:0] chr, logic [6:0] lim);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, lim, chr};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests_sent++;
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_CR || c == CH_LF || c == CH_BS || c == CH_DEL);
    return c;
  endfunction

  // Type n_chars characters with occasional erasures, then the newlines.
  task automatic type_line(int n_chars, int newlines, int erase_pct);
    for (int i = 0; i < n_chars; i++) begin
      if ($urandom_range(0, 99) < erase_pct)
        send_request(OP_BYTE, $urandom_range(0, 1) ? CH_BS : CH_DEL,
                     7'($urandom_range(0, 127)));
      send_request(OP_BYTE, text_char(), 7'($urandom_range(0, 127)));
    end
    for (int i = 0; i < newlines; i++)
      send_request(OP_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF,
                   7'($urandom_range(0, 127)));
  endtask

  initial begin
    rx_pace_t pace;
    int pace_left;
    int phase;
    bit held;
    pace = RX_STEADY;
    pace_left = 0;
    phase = 0;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && requests_taken >= 40) begin
        // long hold-off: let the block back up into its input
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (pace_left == 0) begin
        pace = rx_pace_t'($urandom_range(0, 3));
        pace_left = $urandom_range(50, 300);
      end
      pace_left--;
      phase++;
      case (pace)
        RX_STEADY:       m_axis_tready <= 1'b1;
        RX_COIN:         m_axis_tready <= ($urandom_range(0, 1) != 0);
        RX_EVERY_FOURTH: m_axis_tready <= (phase % 4 == 0);
        default:         m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
      @(posedge clk);
    end
  end

  initial begin
    int pick;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no line ready, erase on empty line, unused opcode
    send_request(OP_READ, 8'h00, 7'd5);
    send_request(OP_BYTE, CH_BS, 7'd0);
    send_request(OP_BYTE, CH_DEL, 7'd127);
    send_request(OP_NONE, 8'hFF, 7'd127);
    // extremes of the byte, both erase codes, then keep typing past the newline
    send_request(OP_BYTE, 8'h00, 7'd127);
    send_request(OP_BYTE, 8'hFF, 7'd0);
    send_request(OP_BYTE, 8'h41, 7'd64);
    send_request(OP_BYTE, CH_DEL, 7'd1);
    send_request(OP_BYTE, CH_BS, 7'd2);
    send_request(OP_BYTE, CH_CR, 7'd3);
    send_request(OP_BYTE, 8'h7E, 7'd0);
    send_request(OP_BYTE, CH_LF, 7'd0);
    send_request(OP_READ, 8'hFF, 7'd127);
    // read limits zero, one and two
    send_request(OP_BYTE, 8'h55, 7'd0);
    send_request(OP_BYTE, CH_CR, 7'd0);
    send_request(OP_READ, 8'h00, 7'd0);
    send_request(OP_BYTE, 8'h33, 7'd0);
    send_request(OP_BYTE, CH_LF, 7'd0);
    send_request(OP_READ, 8'h00, 7'd1);
    send_request(OP_BYTE, 8'h20, 7'd0);
    send_request(OP_BYTE, CH_LF, 7'd0);
    send_request(OP_READ, 8'h00, 7'd2);
    // clear drops the ready mark
    send_request(OP_BYTE, CH_LF, 7'd0);
    send_request(OP_CLEAR, 8'hAA, 7'd85);
    send_request(OP_READ, 8'h00, 7'd10);

    // fill the store: extra characters dropped, second newline not stored
    type_line(66, 2, 0);
    send_request(OP_BYTE, text_char(), 7'd0);
    send_request(OP_READ, 8'($urandom_range(0, 255)), 7'd127);

    while (requests_sent < REQUEST_MIN) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        type_line($urandom_range(58, 70), $urandom_range(1, 2), 0);
        send_request(OP_READ, 8'($urandom_range(0, 255)), 7'($urandom_range(40, 127)));
      end else if (pick < 68) begin
        type_line($urandom_range(0, 10), $urandom_range(1, 2), 15);
        if ($urandom_range(0, 4) == 0)
          type_line($urandom_range(1, 3), 0, 20);
        send_request(OP_READ, 8'($urandom_range(0, 255)),
                     ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 3))
                                                 : 7'($urandom_range(0, 127)));
      end else begin
        send_request(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     7'($urandom_range(0, 127)));
      end
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (LINE_DEPTH + 16) @(posedge clk);
    if (board.mismatches == 0 && board.pending_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
